FILE: src/mx3_pkg.sv
// ----------------------------------------------------------------------------
// mx3_pkg: shared types and constants of the 3x3 matrix operation unit
// Item formats, operation codes, the microword layout and the program
// entry points used by the sequencer and its control store.
// ----------------------------------------------------------------------------
`default_nettype none

package mx3_pkg;

  // Matrix geometry and field widths.
  localparam int DIM            = 3;
  localparam int CELLS          = DIM * DIM;
  localparam int IDX_W          = 4;
  localparam int IN_ELEM_W      = 8;
  localparam int ELEM_WIDTH_MAX = 16;
  localparam int ELEM_WIDTH_DEF = 8;
  localparam int VALUE_W        = 25;
  localparam int SCALAR_W       = 4;
  localparam int PC_W           = 6;

  localparam logic [1:0]          LAST_POS   = 2'(DIM - 1);
  localparam logic [IDX_W-1:0]    CELLS_IDX  = IDX_W'(CELLS);
  localparam logic [SCALAR_W-1:0] SCALAR_MAX = 4'd9;

  // Result source codes.
  localparam logic [1:0] SRC_AB = 2'd2;

  // Operation codes of an input item.
  typedef enum logic [2:0] {
    OP_LOAD_A = 3'd0,
    OP_LOAD_B = 3'd1,
    OP_MUL    = 3'd2,
    OP_ADD    = 3'd3,
    OP_SUB    = 3'd4,
    OP_DET    = 3'd5,
    OP_TRN    = 3'd6,
    OP_SCALE  = 3'd7
  } op_t;

  // Input item.
  typedef struct packed {
    logic [2:0]                  op;
    logic [IDX_W-1:0]            elem_index;
    logic signed [IN_ELEM_W-1:0] elem_value;
    logic [SCALAR_W-1:0]         scalar;
  } in_t;

  // Result item.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [1:0]                source;
    logic [1:0]                row;
    logic [1:0]                col;
    logic                      last;
  } out_t;

  // Element write request from an accepted load item.
  typedef struct packed {
    logic                        wr_a;
    logic                        wr_b;
    logic [IDX_W-1:0]            idx;
    logic signed [IN_ELEM_W-1:0] value;
  } load_t;

  // Address modes of the two matrix read ports.
  typedef enum logic [2:0] {
    AM_RC  = 3'd0,   // row * 3 + col
    AM_CR  = 3'd1,   // col * 3 + row
    AM_RK  = 3'd2,   // row * 3 + k
    AM_KC  = 3'd3,   // k * 3 + col
    AM_LIT = 3'd4    // literal from the microword
  } addr_mode_t;

  // First multiplier operand.
  typedef enum logic [1:0] {
    SA_A    = 2'd0,
    SA_B    = 2'd1,
    SA_SRC  = 2'd2,
    SA_PROD = 2'd3
  } sel_a_t;

  // Second multiplier operand.
  typedef enum logic [1:0] {
    SB_ONE    = 2'd0,
    SB_B      = 2'd1,
    SB_SRC    = 2'd2,
    SB_SCALAR = 2'd3
  } sel_b_t;

  // Accumulator operation.
  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_t;

  // Index counter action.
  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_K    = 2'd1,
    CNT_CELL = 2'd2,
    CNT_SRC  = 2'd3
  } cnt_op_t;

  // Jump condition.
  typedef enum logic [1:0] {
    JC_NONE = 2'd0,
    JC_CELL = 2'd1,   // not at the last cell of the matrix
    JC_ALL  = 2'd2,   // not at the last cell of matrix B
    JC_SRC  = 2'd3    // still on matrix A
  } jump_t;

  // One control word of the program.
  typedef struct packed {
    addr_mode_t       am_a;
    addr_mode_t       am_b;
    logic [IDX_W-1:0] lit;
    sel_a_t           sel_a;
    sel_b_t           sel_b;
    acc_op_t          acc;
    logic             emit;
    cnt_op_t          cnt;
    jump_t            jc;
    logic             src_ab;
    logic             done;
    logic [PC_W-1:0]  target;
  } uword_t;

  // Control from the sequencer to the datapath and the output stage.
  typedef struct packed {
    uword_t     uw;
    logic [1:0] row;
    logic [1:0] col;
    logic [1:0] k;
    logic       src;
    logic       step;
    logic       last;
  } ctl_t;

  // Program entry points.
  localparam logic [PC_W-1:0] PC_MUL = 6'd0;
  localparam logic [PC_W-1:0] PC_ADD = 6'd4;
  localparam logic [PC_W-1:0] PC_SUB = 6'd7;
  localparam logic [PC_W-1:0] PC_TRN = 6'd10;
  localparam logic [PC_W-1:0] PC_SCL = 6'd12;
  localparam logic [PC_W-1:0] PC_DET = 6'd14;

endpackage

`default_nettype wire

FILE: src/matrix3x3_operation_unit_top.sv
// ----------------------------------------------------------------------------
// matrix3x3_operation_unit_top: 3x3 signed matrix operation unit
// Stores matrices A and B and runs product, sum, difference, determinant,
// transpose and scale under a microcoded sequencer.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A load item gives no result. A
// computing item is accepted and then runs its program on one shared
// multiplier, one step per cycle when the result channel keeps up: product
// 36 steps (four per element), sum and difference 27 (three per element),
// determinant 38 (nineteen per matrix), transpose and scale 36 (two per
// element of A, then of B). The next item is taken in the cycle after the
// last step, while the last result may still wait in the output register.
// A scale item with a scalar outside 1..9 is accepted and gives no result.
// Reading an element that was never loaded gives an undefined value.
`default_nettype none

module matrix3x3_operation_unit_top #(
  parameter int ELEM_WIDTH = mx3_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mx3_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mx3_pkg::out_t      out_data
);

  import mx3_pkg::*;

  logic                      in_fire;
  logic                      is_load;
  logic                      scalar_ok;
  logic                      start;
  logic                      busy;
  logic                      hold;
  load_t                     load;
  ctl_t                      ctl;
  logic signed [VALUE_W-1:0] value;
  logic                      out_valid_r, out_valid_nxt;
  out_t                      out_data_r;
  out_t                      res;

  // Input acceptance and dispatch.
  assign in_ready  = !busy;
  assign in_fire   = in_valid && in_ready;
  assign is_load   = (op_t'(in_data.op) == OP_LOAD_A) || (op_t'(in_data.op) == OP_LOAD_B);
  assign scalar_ok = (in_data.scalar != '0) && (in_data.scalar <= SCALAR_MAX);
  assign start     = in_fire && !is_load &&
                     !((op_t'(in_data.op) == OP_SCALE) && !scalar_ok);

  // Element writes; an index past the last cell is dropped.
  assign load.wr_a  = in_fire && (op_t'(in_data.op) == OP_LOAD_A) &&
                      (in_data.elem_index < CELLS_IDX);
  assign load.wr_b  = in_fire && (op_t'(in_data.op) == OP_LOAD_B) &&
                      (in_data.elem_index < CELLS_IDX);
  assign load.idx   = in_data.elem_index;
  assign load.value = in_data.elem_value;

  assign hold = out_valid_r && !out_ready;

  mx3_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_data.op),
    .hold  (hold),
    .busy  (busy),
    .ctl   (ctl)
  );

  mx3_datapath #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk    (clk),
    .load   (load),
    .start  (start),
    .scalar (in_data.scalar),
    .ctl    (ctl),
    .value  (value)
  );

  // Result item assembled from the accumulator and the counters.
  always_comb begin
    res.value  = value;
    res.source = ctl.uw.src_ab ? SRC_AB : {1'b0, ctl.src};
    res.row    = ctl.row;
    res.col    = ctl.col;
    res.last   = ctl.last;
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.step && ctl.uw.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step && ctl.uw.emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: src/mx3_ucode_rom.sv
// ----------------------------------------------------------------------------
// mx3_ucode_rom: control store of the matrix operation unit
// Read-only program of 33 microwords, one per step, looked up by the
// sequencer's program counter.
// ----------------------------------------------------------------------------
`default_nettype none

module mx3_ucode_rom (
  input  wire logic [mx3_pkg::PC_W-1:0] pc,
  output mx3_pkg::uword_t               uw
);

  import mx3_pkg::*;

  // First step of a determinant term: fetch one element times one.
  function automatic uword_t det_fetch(logic [IDX_W-1:0] lit, acc_op_t acc);
    uword_t w;
    w       = '0;
    w.am_a  = AM_LIT;
    w.am_b  = AM_LIT;
    w.lit   = lit;
    w.sel_a = SA_SRC;
    w.sel_b = SB_ONE;
    w.acc   = acc;
    return w;
  endfunction

  // Further step of a determinant term: product so far times an element.
  function automatic uword_t det_mult(logic [IDX_W-1:0] lit);
    uword_t w;
    w       = '0;
    w.am_a  = AM_LIT;
    w.am_b  = AM_LIT;
    w.lit   = lit;
    w.sel_a = SA_PROD;
    w.sel_b = SB_SRC;
    return w;
  endfunction

  // Program lookup. Each term of the Sarrus rule is accumulated at the fetch
  // of the following term, the last one at the emitting step.
  always_comb begin
    uw      = '0;
    uw.done = 1'b1;
    unique case (pc)
      // Product: three multiply-accumulate steps per element, then an emit step.
      PC_MUL, PC_MUL + 6'd1, PC_MUL + 6'd2: begin
        uw.done  = 1'b0;
        uw.am_a  = AM_RK;
        uw.am_b  = AM_KC;
        uw.sel_a = SA_A;
        uw.sel_b = SB_B;
        uw.cnt   = CNT_K;
        uw.acc   = (pc == PC_MUL) ? ACC_HOLD :
                   (pc == PC_MUL + 6'd1) ? ACC_LOAD : ACC_ADD;
      end
      PC_MUL + 6'd3: begin
        uw.acc    = ACC_ADD;
        uw.emit   = 1'b1;
        uw.cnt    = CNT_CELL;
        uw.jc     = JC_CELL;
        uw.src_ab = 1'b1;
        uw.target = PC_MUL;
      end
      // Sum and difference: pass A, pass B, combine.
      PC_ADD, PC_SUB: begin
        uw.done  = 1'b0;
        uw.am_a  = AM_RC;
        uw.sel_a = SA_A;
        uw.sel_b = SB_ONE;
      end
      PC_ADD + 6'd1, PC_SUB + 6'd1: begin
        uw.done  = 1'b0;
        uw.am_b  = AM_RC;
        uw.sel_a = SA_B;
        uw.sel_b = SB_ONE;
        uw.acc   = ACC_LOAD;
      end
      PC_ADD + 6'd2, PC_SUB + 6'd2: begin
        uw.acc    = (pc == PC_ADD + 6'd2) ? ACC_ADD : ACC_SUB;
        uw.emit   = 1'b1;
        uw.cnt    = CNT_CELL;
        uw.jc     = JC_CELL;
        uw.src_ab = 1'b1;
        uw.target = (pc == PC_ADD + 6'd2) ? PC_ADD : PC_SUB;
      end
      // Transpose and scale: one element of A or B per pass.
      PC_TRN, PC_SCL: begin
        uw.done  = 1'b0;
        uw.am_a  = (pc == PC_TRN) ? AM_CR : AM_RC;
        uw.am_b  = (pc == PC_TRN) ? AM_CR : AM_RC;
        uw.sel_a = SA_SRC;
        uw.sel_b = (pc == PC_TRN) ? SB_ONE : SB_SCALAR;
      end
      PC_TRN + 6'd1, PC_SCL + 6'd1: begin
        uw.acc    = ACC_LOAD;
        uw.emit   = 1'b1;
        uw.cnt    = CNT_CELL;
        uw.jc     = JC_ALL;
        uw.target = (pc == PC_TRN + 6'd1) ? PC_TRN : PC_SCL;
      end
      // Determinant: six triple products, positive and negative in turn.
      PC_DET:          uw = det_fetch(4'd0, ACC_HOLD);
      PC_DET + 6'd1:   uw = det_mult(4'd4);
      PC_DET + 6'd2:   uw = det_mult(4'd8);
      PC_DET + 6'd3:   uw = det_fetch(4'd2, ACC_LOAD);
      PC_DET + 6'd4:   uw = det_mult(4'd4);
      PC_DET + 6'd5:   uw = det_mult(4'd6);
      PC_DET + 6'd6:   uw = det_fetch(4'd1, ACC_SUB);
      PC_DET + 6'd7:   uw = det_mult(4'd5);
      PC_DET + 6'd8:   uw = det_mult(4'd6);
      PC_DET + 6'd9:   uw = det_fetch(4'd1, ACC_ADD);
      PC_DET + 6'd10:  uw = det_mult(4'd3);
      PC_DET + 6'd11:  uw = det_mult(4'd8);
      PC_DET + 6'd12:  uw = det_fetch(4'd2, ACC_SUB);
      PC_DET + 6'd13:  uw = det_mult(4'd3);
      PC_DET + 6'd14:  uw = det_mult(4'd7);
      PC_DET + 6'd15:  uw = det_fetch(4'd0, ACC_ADD);
      PC_DET + 6'd16:  uw = det_mult(4'd5);
      PC_DET + 6'd17:  uw = det_mult(4'd7);
      PC_DET + 6'd18: begin
        uw.acc    = ACC_SUB;
        uw.emit   = 1'b1;
        uw.cnt    = CNT_SRC;
        uw.jc     = JC_SRC;
        uw.target = PC_DET;
      end
      default: begin
        uw      = '0;
        uw.done = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/mx3_datapath.sv
// ----------------------------------------------------------------------------
// mx3_datapath: matrix storage, multiplier and accumulator
// Holds matrices A and B, one read port each, a shared multiplier with a
// product register and a wrapping accumulator steered by the microword.
// ----------------------------------------------------------------------------
`default_nettype none

module mx3_datapath #(
  parameter int ELEM_WIDTH = mx3_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire mx3_pkg::load_t                      load,
  input  wire logic                                start,
  input  wire logic [mx3_pkg::SCALAR_W-1:0]        scalar,
  input  wire mx3_pkg::ctl_t                       ctl,
  output logic signed [mx3_pkg::VALUE_W-1:0]       value
);

  import mx3_pkg::*;

  logic signed [ELEM_WIDTH-1:0]     mat_a_r [0:CELLS-1];
  logic signed [ELEM_WIDTH-1:0]     mat_b_r [0:CELLS-1];
  logic [IDX_W-1:0]                 addr_a;
  logic [IDX_W-1:0]                 addr_b;
  logic signed [ELEM_WIDTH-1:0]     rd_a;
  logic signed [ELEM_WIDTH-1:0]     rd_b;
  logic signed [ELEM_WIDTH-1:0]     rd_src;
  logic signed [ELEM_WIDTH_MAX-1:0] load_ext;
  logic signed [VALUE_W-1:0]        mul_a;
  logic signed [VALUE_W-1:0]        mul_b;
  logic signed [2*VALUE_W-1:0]      prod_full;
  logic signed [VALUE_W-1:0]        mul_r;
  logic signed [VALUE_W-1:0]        acc_r;
  logic signed [VALUE_W-1:0]        acc_nxt;
  logic [SCALAR_W-1:0]              scalar_r;

  // Element address for one read port.
  function automatic logic [IDX_W-1:0] addr_of(addr_mode_t m, logic [1:0] r,
                                               logic [1:0] c, logic [1:0] k,
                                               logic [IDX_W-1:0] lit);
    logic [IDX_W-1:0] a;
    unique case (m)
      AM_RC:   a = IDX_W'(r) * IDX_W'(DIM) + IDX_W'(c);
      AM_CR:   a = IDX_W'(c) * IDX_W'(DIM) + IDX_W'(r);
      AM_RK:   a = IDX_W'(r) * IDX_W'(DIM) + IDX_W'(k);
      AM_KC:   a = IDX_W'(k) * IDX_W'(DIM) + IDX_W'(c);
      AM_LIT:  a = lit;
      default: a = lit;
    endcase
    return a;
  endfunction

  // Loaded value is sign-extended, then cut to the element width.
  assign load_ext = ELEM_WIDTH_MAX'(load.value);

  // Element writes from load items.
  always_ff @(posedge clk) begin
    if (load.wr_a) begin
      mat_a_r[load.idx] <= load_ext[ELEM_WIDTH-1:0];
    end
    if (load.wr_b) begin
      mat_b_r[load.idx] <= load_ext[ELEM_WIDTH-1:0];
    end
  end

  // One read port on each matrix.
  assign addr_a = addr_of(ctl.uw.am_a, ctl.row, ctl.col, ctl.k, ctl.uw.lit);
  assign addr_b = addr_of(ctl.uw.am_b, ctl.row, ctl.col, ctl.k, ctl.uw.lit);
  assign rd_a   = mat_a_r[addr_a];
  assign rd_b   = mat_b_r[addr_b];
  assign rd_src = ctl.src ? rd_b : rd_a;

  // Multiplier operand selection.
  always_comb begin
    case (ctl.uw.sel_a)
      SA_A:    mul_a = VALUE_W'(rd_a);
      SA_B:    mul_a = VALUE_W'(rd_b);
      SA_SRC:  mul_a = VALUE_W'(rd_src);
      default: mul_a = mul_r;
    endcase
    case (ctl.uw.sel_b)
      SB_B:      mul_b = VALUE_W'(rd_b);
      SB_SRC:    mul_b = VALUE_W'(rd_src);
      SB_SCALAR: mul_b = VALUE_W'(scalar_r);
      default:   mul_b = VALUE_W'(1);
    endcase
  end

  // Results wrap to the value width, so only the low product bits are kept.
  assign prod_full = mul_a * mul_b;

  // Accumulator operation.
  always_comb begin
    case (ctl.uw.acc)
      ACC_LOAD: acc_nxt = mul_r;
      ACC_ADD:  acc_nxt = acc_r + mul_r;
      ACC_SUB:  acc_nxt = acc_r - mul_r;
      default:  acc_nxt = acc_r;
    endcase
  end

  assign value = acc_nxt;

  // Product and accumulator registers advance only on an executed step.
  always_ff @(posedge clk) begin
    if (start) begin
      scalar_r <= scalar;
    end
    if (ctl.step) begin
      mul_r <= prod_full[VALUE_W-1:0];
      acc_r <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/mx3_sequencer.sv
// ----------------------------------------------------------------------------
// mx3_sequencer: program counter and index counters
// Steps through the control store, evaluates conditional jumps on the row,
// column and matrix counters, and stalls on a full output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mx3_sequencer (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [2:0]     op,
  input  wire logic           hold,
  output logic                busy,
  output mx3_pkg::ctl_t       ctl
);

  import mx3_pkg::*;

  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [1:0]      row_r, row_nxt;
  logic [1:0]      col_r, col_nxt;
  logic [1:0]      k_r, k_nxt;
  logic            src_r, src_nxt;
  uword_t          uw;
  logic            step;
  logic            cell_end;
  logic            jump;
  logic [PC_W-1:0] entry;

  mx3_ucode_rom u_rom (
    .pc (pc_r),
    .uw (uw)
  );

  // Program entry for each computing operation.
  always_comb begin
    unique case (op_t'(op))
      OP_MUL:   entry = PC_MUL;
      OP_ADD:   entry = PC_ADD;
      OP_SUB:   entry = PC_SUB;
      OP_DET:   entry = PC_DET;
      OP_TRN:   entry = PC_TRN;
      OP_SCALE: entry = PC_SCL;
      default:  entry = PC_MUL;
    endcase
  end

  // A step that emits waits while the output stage is full.
  assign step     = busy_r && !(uw.emit && hold);
  assign cell_end = (row_r == LAST_POS) && (col_r == LAST_POS);

  always_comb begin
    case (uw.jc)
      JC_CELL: jump = !cell_end;
      JC_ALL:  jump = !(cell_end && src_r);
      JC_SRC:  jump = !src_r;
      default: jump = 1'b0;
    endcase
  end

  // Next program counter and counter values.
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    k_nxt    = k_r;
    src_nxt  = src_r;
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = entry;
      row_nxt  = '0;
      col_nxt  = '0;
      k_nxt    = '0;
      src_nxt  = 1'b0;
    end else if (step) begin
      if (jump) begin
        pc_nxt = uw.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
      if (uw.done && !jump) begin
        busy_nxt = 1'b0;
      end
      case (uw.cnt)
        CNT_K: begin
          k_nxt = (k_r == LAST_POS) ? 2'd0 : k_r + 2'd1;
        end
        CNT_CELL: begin
          k_nxt = '0;
          if (col_r == LAST_POS) begin
            col_nxt = '0;
            if (row_r == LAST_POS) begin
              row_nxt = '0;
              src_nxt = ~src_r;
            end else begin
              row_nxt = row_r + 2'd1;
            end
          end else begin
            col_nxt = col_r + 2'd1;
          end
        end
        CNT_SRC: begin
          row_nxt = '0;
          col_nxt = '0;
          k_nxt   = '0;
          src_nxt = ~src_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
      row_r  <= '0;
      col_r  <= '0;
      k_r    <= '0;
      src_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      k_r    <= k_nxt;
      src_r  <= src_nxt;
    end
  end

  assign busy     = busy_r;
  assign ctl.uw   = uw;
  assign ctl.row  = row_r;
  assign ctl.col  = col_r;
  assign ctl.k    = k_r;
  assign ctl.src  = src_r;
  assign ctl.step = step;
  assign ctl.last = uw.done && !jump;

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the 3x3 matrix operation unit
// Loads both matrices, then drives directed and random items through the
// valid/ready input channel while the result channel stalls at random. Each
// accepted item is run through a local model of the unit, and every result
// element is compared field by field against the oldest predicted element.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import mx3_pkg::*;

  localparam int ELEM_W      = ELEM_WIDTH_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 64;

  // Source codes for results taken from a single matrix.
  localparam logic [1:0] SRC_A = 2'd0;
  localparam logic [1:0] SRC_B = 2'd1;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // Local copy of the stored matrices and the queue of predicted elements.
  logic signed [ELEM_W-1:0] mat_a [CELLS];
  logic signed [ELEM_W-1:0] mat_b [CELLS];
  out_t result_elems [$];
  out_t oldest_elem;

  int mismatch_count = 0;
  int stall_cycles   = 0;
  int hold_cycles    = 0;
  int in_idle_pct    = 0;
  int out_idle_pct   = 0;

  matrix3x3_operation_unit_top #(
    .ELEM_WIDTH(ELEM_W)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Clock with a period of four time units.
  always #2 clk = ~clk;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  // Read one stored element of A or B, sign-extended.
  function automatic longint elem_at(input bit from_b, input int idx);
    longint v;
    if (from_b) v = mat_b[idx];
    else v = mat_a[idx];
    return v;
  endfunction

  // Determinant by the rule of Sarrus: three forward and three backward
  // diagonals.
  function automatic longint sarrus_det(input bit from_b);
    longint sum;
    longint pos;
    longint neg;
    int c;
    sum = 0;
    for (int i = 0; i < DIM; i++) begin
      pos = 1;
      neg = 1;
      for (int j = 0; j < DIM; j++) begin
        c = (i + j) % DIM;
        pos *= elem_at(from_b, j * DIM + c);
        neg *= elem_at(from_b, j * DIM + (DIM - 1 - c));
      end
      sum += pos - neg;
    end
    return sum;
  endfunction

  // Append one predicted element, wrapped to the width of the value field.
  function automatic void push_elem(input longint v, input logic [1:0] src,
                                    input int r, input int c, input bit is_last);
    out_t e;
    e.value  = v[VALUE_W-1:0];
    e.source = src;
    e.row    = 2'(r);
    e.col    = 2'(c);
    e.last   = is_last;
    result_elems.push_back(e);
  endfunction

  // Update the matrix copy or predict the elements an accepted item gives.
  function automatic void compute_matrix_op(input in_t it);
    op_t    op;
    longint v;
    bit     scalar_ok;
    op = op_t'(it.op);
    scalar_ok = (it.scalar >= 1) && (it.scalar <= SCALAR_MAX);
    case (op)
      OP_LOAD_A, OP_LOAD_B: begin
        // Loads beyond the last cell are ignored.
        if (it.elem_index < CELLS_IDX) begin
          if (op == OP_LOAD_A) mat_a[it.elem_index] = $signed(it.elem_value);
          else mat_b[it.elem_index] = $signed(it.elem_value);
        end
      end
      OP_MUL, OP_ADD, OP_SUB: begin
        for (int r = 0; r < DIM; r++) begin
          for (int c = 0; c < DIM; c++) begin
            if (op == OP_MUL) begin
              v = 0;
              for (int k = 0; k < DIM; k++)
                v += elem_at(1'b0, r * DIM + k) * elem_at(1'b1, k * DIM + c);
            end else if (op == OP_ADD) begin
              v = elem_at(1'b0, r * DIM + c) + elem_at(1'b1, r * DIM + c);
            end else begin
              v = elem_at(1'b0, r * DIM + c) - elem_at(1'b1, r * DIM + c);
            end
            push_elem(v, SRC_AB, r, c, (r == DIM - 1) && (c == DIM - 1));
          end
        end
      end
      OP_DET: begin
        push_elem(sarrus_det(1'b0), SRC_A, 0, 0, 1'b0);
        push_elem(sarrus_det(1'b1), SRC_B, 0, 0, 1'b1);
      end
      default: begin
        // Transpose, or scale with a scalar in range: A first, then B.
        if (op == OP_TRN || scalar_ok) begin
          for (int s = 0; s < 2; s++) begin
            for (int r = 0; r < DIM; r++) begin
              for (int c = 0; c < DIM; c++) begin
                if (op == OP_TRN) v = elem_at(s[0], c * DIM + r);
                else v = elem_at(s[0], r * DIM + c) * longint'(it.scalar);
                push_elem(v, s[0] ? SRC_B : SRC_A, r, c,
                          (s == 1) && (r == DIM - 1) && (c == DIM - 1));
              end
            end
          end
        end
      end
    endcase
  endfunction

  function automatic in_t make_item(input op_t op, input int idx, input int val,
                                    input int scl);
    in_t it;
    it.op         = op;
    it.elem_index = IDX_W'(idx);
    it.elem_value = IN_ELEM_W'(val);
    it.scalar     = SCALAR_W'(scl);
    return it;
  endfunction

  // Random item: loads and computing operations mixed, with all fields
  // random and mostly well-formed indexes and scalars.
  function automatic in_t random_item();
    in_t it;
    it.op         = 3'($urandom_range(7));
    it.elem_index = IDX_W'($urandom_range(15));
    it.elem_value = IN_ELEM_W'($urandom);
    it.scalar     = SCALAR_W'($urandom_range(15));
    if ($urandom_range(99) < 40) begin
      it.op = $urandom_range(1) ? OP_LOAD_B : OP_LOAD_A;
      if ($urandom_range(9) != 0) it.elem_index = IDX_W'($urandom_range(CELLS - 1));
      if ($urandom_range(4) == 0) it.elem_value = $urandom_range(1) ? 8'sh80 : 8'sh7f;
    end else begin
      it.op = 3'($urandom_range(OP_SCALE, OP_MUL));
      if (it.op == OP_SCALE && $urandom_range(7) != 0)
        it.scalar = SCALAR_W'($urandom_range(SCALAR_MAX, 1));
    end
    return it;
  endfunction

  // Offer one item after a random gap and wait until it is accepted. Valid
  // stays high on return so that back-to-back items need no gap.
  task automatic send_item(input in_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    compute_matrix_op(it);
    @(negedge clk);
  endtask

  // Stop offering items until every predicted element has arrived.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (result_elems.size() != 0) @(negedge clk);
  endtask

  // Full load of both matrices with extreme values, ignored loads, then
  // every operation, including scale at both ends and out of range.
  task automatic test_directed();
    int a_vals [CELLS];
    int b_vals [CELLS];
    a_vals = '{-128, 127, 0, 1, -1, 127, -128, 5, -128};
    b_vals = '{127, 127, -128, -128, 127, 127, 127, -128, 127};
    for (int i = 0; i < CELLS; i++) send_item(make_item(OP_LOAD_A, i, a_vals[i], 0));
    for (int i = 0; i < CELLS; i++) send_item(make_item(OP_LOAD_B, i, b_vals[i], 15));
    send_item(make_item(OP_LOAD_A, 15, -1, 0));
    send_item(make_item(OP_LOAD_B, CELLS, 0, 0));
    send_item(make_item(OP_MUL, 0, 0, 0));
    send_item(make_item(OP_ADD, 0, 0, 0));
    send_item(make_item(OP_SUB, 0, 0, 0));
    send_item(make_item(OP_DET, 0, 0, 0));
    send_item(make_item(OP_TRN, 0, 0, 0));
    send_item(make_item(OP_SCALE, 0, 0, 1));
    send_item(make_item(OP_SCALE, 0, 0, 9));
    send_item(make_item(OP_SCALE, 0, 0, 0));
    send_item(make_item(OP_SCALE, 15, -1, 15));
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_item(random_item());
  endtask

  // The receiver holds off for a long stretch while computing items keep
  // coming, so the unit fills up and stalls its input.
  task automatic test_backpressure();
    in_t it;
    hold_cycles = HOLD_CYCLES;
    for (int i = 0; i < 8; i++) begin
      it = random_item();
      it.op = 3'($urandom_range(OP_SCALE, OP_MUL));
      send_item(it);
    end
    wait_drained();
    test_random(6);
  endtask

  // Result channel: a long hold-off when requested, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready = 1'b0;
      hold_cycles--;
    end else begin
      out_ready = ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Compare each accepted result element with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (result_elems.size() == 0) begin
        report_mismatch($sformatf("unexpected element value=%0d src=%0d r=%0d c=%0d last=%0b",
                                  out_data.value, out_data.source, out_data.row,
                                  out_data.col, out_data.last));
      end else begin
        oldest_elem = result_elems.pop_front();
        if (out_data.value !== oldest_elem.value)
          report_mismatch($sformatf("value %0d, expected %0d",
                                    out_data.value, oldest_elem.value));
        if (out_data.source !== oldest_elem.source)
          report_mismatch($sformatf("source %0d, expected %0d",
                                    out_data.source, oldest_elem.source));
        if (out_data.row !== oldest_elem.row)
          report_mismatch($sformatf("row %0d, expected %0d", out_data.row, oldest_elem.row));
        if (out_data.col !== oldest_elem.col)
          report_mismatch($sformatf("col %0d, expected %0d", out_data.col, oldest_elem.col));
        if (out_data.last !== oldest_elem.last)
          report_mismatch($sformatf("last %0b, expected %0b",
                                    out_data.last, oldest_elem.last));
      end
    end
  end

  // Watchdog: end the run when nothing is accepted for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    in_idle_pct  = 38;
    out_idle_pct = 54;
    test_directed();
    test_random(22);
    wait_drained();

    in_idle_pct  = 54;
    out_idle_pct = 38;
    test_random(22);
    wait_drained();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random(14);
    test_backpressure();

    // Drain, then watch for stray elements before the verdict.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (result_elems.size() != 0)
      report_mismatch($sformatf("%0d elements never arrived", result_elems.size()));
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
src/mx3_pkg.sv
src/mx3_ucode_rom.sv
src/mx3_datapath.sv
src/mx3_sequencer.sv
src/matrix3x3_operation_unit_top.sv
dv/tb_top.sv
